/* hdl/qoie_pkg.sv */
// qoie_pkg: shared types, constants and the color hash of the qoi image encoder
// no dependencies; imported by qoie_op_encoder and qoi_image_encoder_core
`default_nettype none

package qoie_pkg;

    // configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;
    localparam int CFG_DATA_W = 32;

    // color index table
    localparam int INDEX_DEPTH = 64;
    localparam int HASH_W      = $clog2(INDEX_DEPTH);
    localparam int PIXEL_W     = 32;

    localparam int HASH_MUL_R = 3;
    localparam int HASH_MUL_G = 5;
    localparam int HASH_MUL_B = 7;
    localparam int HASH_MUL_A = 11;

    // op codes and file bytes
    localparam logic [7:0] OP_DIFF  = 8'h40;
    localparam logic [7:0] OP_LUMA  = 8'h80;
    localparam logic [7:0] OP_RUN   = 8'hC0;
    localparam logic [7:0] OP_RGB   = 8'hFE;
    localparam logic [7:0] OP_RGBA  = 8'hFF;

    localparam logic [7:0] MAGIC_Q    = 8'h71;
    localparam logic [7:0] MAGIC_O    = 8'h6F;
    localparam logic [7:0] MAGIC_I    = 8'h69;
    localparam logic [7:0] MAGIC_F    = 8'h66;
    localparam logic [7:0] CHANNELS   = 8'h04;
    localparam logic [7:0] COLORSPACE = 8'h00;
    localparam logic [7:0] PAD_BYTE   = 8'h00;
    localparam logic [7:0] END_BYTE   = 8'h01;

    localparam logic [5:0] RUN_MAX = 6'd62;
    localparam int RUN_W = 6;

    localparam logic [7:0] DIFF_BIAS     = 8'd2;
    localparam logic [7:0] DIFF_SPAN     = 8'd4;
    localparam logic [7:0] LUMA_G_BIAS   = 8'd32;
    localparam logic [7:0] LUMA_G_SPAN   = 8'd64;
    localparam logic [7:0] LUMA_RB_BIAS  = 8'd8;
    localparam logic [7:0] LUMA_RB_SPAN  = 8'd16;

    // byte slots of one item's output, in emit order
    localparam int HDR_SLOTS    = 14;
    localparam int OP_MAX       = 5;
    localparam int FOOTER_SLOTS = 8;
    localparam int NUM_SLOTS    = HDR_SLOTS + 1 + OP_MAX + 1 + FOOTER_SLOTS;
    localparam int SLOT_W       = $clog2(NUM_SLOTS);
    localparam int OP_IDX_W     = $clog2(OP_MAX);
    localparam int OP_LEN_W     = $clog2(OP_MAX + 1);

    localparam logic [SLOT_W-1:0] SLOT_PRE  = SLOT_W'(HDR_SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_OP   = SLOT_W'(HDR_SLOTS + 1);
    localparam logic [SLOT_W-1:0] SLOT_POST = SLOT_W'(HDR_SLOTS + 1 + OP_MAX);
    localparam logic [SLOT_W-1:0] SLOT_END  = SLOT_W'(NUM_SLOTS - 1);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    localparam pixel_t PREV_RESET = '{red: 8'h00, green: 8'h00, blue: 8'h00, alpha: 8'hFF};

    // bytes produced by one pixel
    typedef struct packed {
        logic                          header;
        logic                          pre_run;
        logic [7:0]                    pre_byte;
        logic [OP_LEN_W-1:0]           op_len;
        logic [OP_MAX-1:0][7:0]        op_bytes;
        logic                          post_run;
        logic [7:0]                    post_byte;
        logic                          footer;
    } pkt_t;

    // encoder state after one pixel
    typedef struct packed {
        pixel_t             prev;
        logic [RUN_W-1:0]   run;
        logic               hdr_sent;
        logic               idx_write;
        logic               idx_clear;
    } enc_state_t;

    function automatic logic [HASH_W-1:0] color_hash(pixel_t p);
        logic [HASH_W-1:0] r3;
        logic [HASH_W-1:0] g5;
        logic [HASH_W-1:0] b7;
        logic [HASH_W-1:0] a11;
        r3  = HASH_W'(p.red   * HASH_MUL_R);
        g5  = HASH_W'(p.green * HASH_MUL_G);
        b7  = HASH_W'(p.blue  * HASH_MUL_B);
        a11 = HASH_W'(p.alpha * HASH_MUL_A);
        return r3 + g5 + b7 + a11;
    endfunction

endpackage

`default_nettype wire

/* hdl/qoie_ram.sv */
// qoie_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module qoie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/qoie_op_encoder.sv */
// qoie_op_encoder: picks the qoi ops for one pixel and the encoder state after it
// depends on qoie_pkg
`default_nettype none

module qoie_op_encoder
    import qoie_pkg::*;
(
    input  wire pixel_t             pix,
    input  wire logic               last,
    input  wire pixel_t             prev,
    input  wire logic [RUN_W-1:0]   run,
    input  wire logic               hdr_sent,
    input  wire pixel_t             entry,
    input  wire logic [HASH_W-1:0]  hash,
    output pkt_t                    pkt,
    output enc_state_t              nxt
);

    logic [7:0] dr;
    logic [7:0] dg;
    logic [7:0] db;
    logic [7:0] drg;
    logic [7:0] dbg;
    logic [7:0] dr_b;
    logic [7:0] dg_b;
    logic [7:0] db_b;
    logic [7:0] dg_l;
    logic [7:0] drg_l;
    logic [7:0] dbg_l;
    logic       diff_ok;
    logic       luma_ok;

    always_comb
    begin
        dr    = pix.red   - prev.red;
        dg    = pix.green - prev.green;
        db    = pix.blue  - prev.blue;
        drg   = dr - dg;
        dbg   = db - dg;
        dr_b  = dr + DIFF_BIAS;
        dg_b  = dg + DIFF_BIAS;
        db_b  = db + DIFF_BIAS;
        dg_l  = dg + LUMA_G_BIAS;
        drg_l = drg + LUMA_RB_BIAS;
        dbg_l = dbg + LUMA_RB_BIAS;
        diff_ok = (dr_b < DIFF_SPAN) && (dg_b < DIFF_SPAN) && (db_b < DIFF_SPAN);
        luma_ok = (dg_l < LUMA_G_SPAN) && (drg_l < LUMA_RB_SPAN) && (dbg_l < LUMA_RB_SPAN);

        pkt           = '0;
        pkt.header    = !hdr_sent;
        nxt.prev      = prev;
        nxt.run       = run;
        nxt.hdr_sent  = 1'b1;
        nxt.idx_write = 1'b0;
        nxt.idx_clear = 1'b0;

        if (pix == prev)
        begin
            if (run >= RUN_MAX)
            begin
                pkt.pre_run  = 1'b1;
                pkt.pre_byte = OP_RUN | {2'b00, RUN_MAX - 6'd1};
                nxt.run      = 6'd1;
            end
            else
            begin
                nxt.run = run + 6'd1;
            end
        end
        else
        begin
            pkt.pre_run   = (run != '0);
            pkt.pre_byte  = OP_RUN | {2'b00, run - 6'd1};
            nxt.run       = '0;
            nxt.prev      = pix;
            nxt.idx_write = 1'b1;
            if (entry == pix)
            begin
                pkt.op_len      = OP_LEN_W'(1);
                pkt.op_bytes[0] = {2'b00, hash};
            end
            else if (pix.alpha == prev.alpha)
            begin
                if (diff_ok)
                begin
                    pkt.op_len      = OP_LEN_W'(1);
                    pkt.op_bytes[0] = OP_DIFF | {2'b00, dr_b[1:0], dg_b[1:0], db_b[1:0]};
                end
                else if (luma_ok)
                begin
                    pkt.op_len      = OP_LEN_W'(2);
                    pkt.op_bytes[0] = OP_LUMA | {2'b00, dg_l[5:0]};
                    pkt.op_bytes[1] = {drg_l[3:0], dbg_l[3:0]};
                end
                else
                begin
                    pkt.op_len      = OP_LEN_W'(4);
                    pkt.op_bytes[0] = OP_RGB;
                    pkt.op_bytes[1] = pix.red;
                    pkt.op_bytes[2] = pix.green;
                    pkt.op_bytes[3] = pix.blue;
                end
            end
            else
            begin
                pkt.op_len      = OP_LEN_W'(5);
                pkt.op_bytes[0] = OP_RGBA;
                pkt.op_bytes[1] = pix.red;
                pkt.op_bytes[2] = pix.green;
                pkt.op_bytes[3] = pix.blue;
                pkt.op_bytes[4] = pix.alpha;
            end
        end

        // end of image: flush run, footer, back to the state after reset
        if (last)
        begin
            pkt.post_run  = (nxt.run != '0);
            pkt.post_byte = OP_RUN | {2'b00, nxt.run - 6'd1};
            pkt.footer    = 1'b1;
            nxt.prev      = PREV_RESET;
            nxt.run       = '0;
            nxt.hdr_sent  = 1'b0;
            nxt.idx_write = 1'b0;
            nxt.idx_clear = 1'b1;
        end
    end

endmodule

`default_nettype wire

/* hdl/qoi_image_encoder_core.sv */
// qoi_image_encoder_core: streaming rgba to qoi byte encoder, top level
// depends on qoie_pkg, qoie_ram and qoie_op_encoder
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata = red, green, blue, alpha; s_tlast = pixel_last
//  m_*       out  m_tvalid/m_tready  m_tdata = out_byte; m_tlast = stream_end
//  cfg_*     in   cfg_we             cfg_addr = register index, cfg_wdata = value
//
// a pixel goes from the input register through the op encoder into the byte register
// when that register is empty; it then drains one byte per cycle while m_tready is high
// the byte register takes a new pixel only once every byte of the last one has been sent
// reset clears the index valid bits at once; no clearing pass is needed
// a stalled output holds the byte register and, once the input register is full, s_tready
`default_nettype none

module qoi_image_encoder_core
    import qoie_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,   // red, green, blue, alpha
    input  wire logic                  s_tlast,   // pixel_last
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,   // out_byte
    output logic                       m_tlast,   // stream_end
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [CFG_DATA_W-1:0]   width_reg;
    logic [CFG_DATA_W-1:0]   height_reg;

    logic                    in_valid_reg;
    pixel_t                  in_pix_reg;
    logic                    in_last_reg;
    logic [HASH_W-1:0]       in_hash_reg;
    logic                    entry_valid_reg;
    logic                    bypass_reg;
    pixel_t                  bypass_data_reg;

    pixel_t                  prev_reg;
    logic [RUN_W-1:0]        run_reg;
    logic                    hdr_sent_reg;
    logic [INDEX_DEPTH-1:0]  idx_valid_reg;
    logic [INDEX_DEPTH-1:0]  idx_valid_next;

    logic [NUM_SLOTS-1:0]    mask_reg;
    logic [NUM_SLOTS-1:0]    mask_next;
    logic [7:0]              pre_byte_reg;
    logic [OP_MAX-1:0][7:0]  op_bytes_reg;
    logic [7:0]              post_byte_reg;

    pixel_t                  s_pix;
    logic [HASH_W-1:0]       s_hash;
    logic                    s_fire;
    logic                    m_fire;
    logic                    pkt_free;
    logic                    enc_fire;
    pixel_t                  ram_rdata;
    pixel_t                  entry;
    pkt_t                    enc_pkt;
    enc_state_t              enc_nxt;
    logic [OP_MAX-1:0]       op_mask;
    logic [SLOT_W-1:0]       slot;
    logic [SLOT_W-1:0]       op_off;
    logic [7:0]              hdr_bytes [HDR_SLOTS];
    logic [7:0]              out_byte;

    assign s_pix    = '{red: s_tdata[7:0], green: s_tdata[15:8],
                        blue: s_tdata[23:16], alpha: s_tdata[31:24]};
    assign s_hash   = color_hash(s_pix);
    assign pkt_free = (mask_reg == '0);
    assign enc_fire = in_valid_reg && pkt_free;
    assign s_tready = !in_valid_reg || pkt_free;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = (mask_reg != '0);
    assign m_fire   = m_tvalid && m_tready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // color index, valid bits kept in flops
    qoie_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (INDEX_DEPTH)
    ) u_index (
        .clk   (clk),
        .we    (enc_fire && enc_nxt.idx_write),
        .waddr (in_hash_reg),
        .wdata (in_pix_reg),
        .re    (s_fire),
        .raddr (s_hash),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        idx_valid_next = idx_valid_reg;
        if (enc_fire && enc_nxt.idx_clear)
        begin
            idx_valid_next = '0;
        end
        else if (enc_fire && enc_nxt.idx_write)
        begin
            idx_valid_next[in_hash_reg] = 1'b1;
        end
    end

    assign entry = !entry_valid_reg ? pixel_t'('0) :
                   (bypass_reg ? bypass_data_reg : ram_rdata);

    qoie_op_encoder u_enc (
        .pix      (in_pix_reg),
        .last     (in_last_reg),
        .prev     (prev_reg),
        .run      (run_reg),
        .hdr_sent (hdr_sent_reg),
        .entry    (entry),
        .hash     (in_hash_reg),
        .pkt      (enc_pkt),
        .nxt      (enc_nxt)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            entry_valid_reg <= 1'b0;
            bypass_reg      <= 1'b0;
        end
        else if (s_fire)
        begin
            in_valid_reg    <= 1'b1;
            entry_valid_reg <= idx_valid_next[s_hash];
            bypass_reg      <= enc_fire && enc_nxt.idx_write && (in_hash_reg == s_hash);
        end
        else if (enc_fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_pix_reg      <= s_pix;
            in_last_reg     <= s_tlast;
            in_hash_reg     <= s_hash;
            bypass_data_reg <= in_pix_reg;
        end
    end

    // encoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= PREV_RESET;
            run_reg       <= '0;
            hdr_sent_reg  <= 1'b0;
            idx_valid_reg <= '0;
        end
        else
        begin
            idx_valid_reg <= idx_valid_next;
            if (enc_fire)
            begin
                prev_reg     <= enc_nxt.prev;
                run_reg      <= enc_nxt.run;
                hdr_sent_reg <= enc_nxt.hdr_sent;
            end
        end
    end

    // byte register: one slot bit per pending byte
    always_comb
    begin
        for (int i = 0; i < OP_MAX; i++)
        begin
            op_mask[i] = (OP_LEN_W'(i) < enc_pkt.op_len);
        end
        mask_next = mask_reg;
        if (enc_fire)
        begin
            mask_next = {{FOOTER_SLOTS{enc_pkt.footer}}, enc_pkt.post_run, op_mask,
                         enc_pkt.pre_run, {HDR_SLOTS{enc_pkt.header}}};
        end
        else if (m_fire)
        begin
            mask_next = mask_reg & (mask_reg - NUM_SLOTS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enc_fire)
        begin
            pre_byte_reg  <= enc_pkt.pre_byte;
            op_bytes_reg  <= enc_pkt.op_bytes;
            post_byte_reg <= enc_pkt.post_byte;
        end
    end

    // output byte select
    always_comb
    begin
        slot = SLOT_END;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                slot = SLOT_W'(i);
            end
        end
        op_off = slot - SLOT_OP;

        hdr_bytes[0]  = MAGIC_Q;
        hdr_bytes[1]  = MAGIC_O;
        hdr_bytes[2]  = MAGIC_I;
        hdr_bytes[3]  = MAGIC_F;
        hdr_bytes[4]  = width_reg[31:24];
        hdr_bytes[5]  = width_reg[23:16];
        hdr_bytes[6]  = width_reg[15:8];
        hdr_bytes[7]  = width_reg[7:0];
        hdr_bytes[8]  = height_reg[31:24];
        hdr_bytes[9]  = height_reg[23:16];
        hdr_bytes[10] = height_reg[15:8];
        hdr_bytes[11] = height_reg[7:0];
        hdr_bytes[12] = CHANNELS;
        hdr_bytes[13] = COLORSPACE;

        if (slot < SLOT_PRE)
        begin
            out_byte = hdr_bytes[slot[3:0]];
        end
        else if (slot == SLOT_PRE)
        begin
            out_byte = pre_byte_reg;
        end
        else if (slot < SLOT_POST)
        begin
            out_byte = op_bytes_reg[op_off[OP_IDX_W-1:0]];
        end
        else if (slot == SLOT_POST)
        begin
            out_byte = post_byte_reg;
        end
        else if (slot == SLOT_END)
        begin
            out_byte = END_BYTE;
        end
        else
        begin
            out_byte = PAD_BYTE;
        end
    end

    assign m_tdata = out_byte;
    assign m_tlast = (slot == SLOT_END);

`ifndef SYNTH
    a_end_alone : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> $onehot(mask_reg))
        else $error("end byte emitted with other bytes pending");

    a_run_bound : assert property (@(posedge clk) disable iff (!rst_n)
        run_reg <= RUN_MAX)
        else $error("run length beyond limit");

    a_image_reset : assert property (@(posedge clk) disable iff (!rst_n)
        (enc_fire && in_last_reg) |=> (!hdr_sent_reg && run_reg == '0 && idx_valid_reg == '0))
        else $error("state not cleared after last pixel");

    a_ready_drain : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tready && in_valid_reg) |-> (mask_reg == '0))
        else $error("input taken while byte register busy");
`endif

endmodule

`default_nettype wire
